// ===== rtl/keyword_hash_filter_lookup_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the keyword hash filter lookup block
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_HASH_FILTER_LOOKUP_ASSERT_SVH
`define KEYWORD_HASH_FILTER_LOOKUP_ASSERT_SVH

// Same-cycle implication
`define KHFL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define KHFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/khfl_pkg.sv =====
// ----------------------------------------------------------------------------
// khfl_pkg
// Shared types and constants of the keyword hash filter lookup block.
// ----------------------------------------------------------------------------
package khfl_pkg;

  localparam int DEFAULT_BUCKETS        = 2048;
  localparam int DEFAULT_NEEDED_ENTRIES = 16;
  localparam int QUEUE_DEPTH            = 4;

  // Input opcodes (carried on tuser)
  localparam logic [1:0] OP_KEY   = 2'd0;
  localparam logic [1:0] OP_DELTA = 2'd1;
  localparam logic [1:0] OP_TABLE = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_BUCKET_MULT  = 3'd0;
  localparam logic [2:0] REG_SLOT_MULT    = 3'd1;
  localparam logic [2:0] REG_BUCKET_COUNT = 3'd2;
  localparam logic [2:0] REG_SLOT_MODULUS = 3'd3;
  localparam logic [2:0] REG_NEEDED_COUNT = 3'd4;

  typedef enum logic [1:0] {
    JOB_LOOKUP,
    JOB_DELTA,
    JOB_TABLE
  } job_kind_t;

  // Queued job: lookup carries both hashes; delta carries the byte in h0;
  // table write carries the index in h0 and the slot in h1.
  typedef struct packed {
    job_kind_t   kind;
    logic [31:0] h0;
    logic [31:0] h1;
  } job_t;

  typedef struct packed {
    logic [31:0] bucket_mult;
    logic [31:0] slot_mult;
    logic [11:0] bucket_count;
    logic [7:0]  slot_modulus;
    logic [4:0]  needed_count;
  } cfg_t;

  typedef struct packed {
    logic [10:0] bucket;
    logic        filter_hit;
    logic [7:0]  slot;
    logic        matched;
    logic [3:0]  needed_index;
  } result_t;

endpackage

// ===== rtl/keyword_hash_filter_lookup.sv =====
// Key bytes: one word per cycle into the hash front while s_tready is high (one 32x32
// multiply per hash). A lookup runs in the back stage through a 32-step bit-serial
// remainder, bitmap read and compare before m_tvalid; no new job is popped meanwhile.
// Filter deltas and table writes are done as they are popped; a 4-entry queue decouples.
// Reset (rst, synchronous) clears control state, then a sweep clears the filter bitmap
// with s_tready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// keyword_hash_filter_lookup
// Streaming keyword hash with bucket filter and perfect-hash slot lookup.
// ----------------------------------------------------------------------------
module keyword_hash_filter_lookup #(
  parameter int BUCKETS        = khfl_pkg::DEFAULT_BUCKETS,
  parameter int NEEDED_ENTRIES = khfl_pkg::DEFAULT_NEEDED_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // data_byte[7:0], entry_index[11:8], entry_slot[19:12]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // bucket[10:0], filter_hit[11], slot[19:12],
                                 // matched[20], needed_index[24:21]
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data
);
  import khfl_pkg::*;

  cfg_t    cfg;
  logic    q_push;
  job_t    q_in;
  logic    q_full;
  logic    q_pop;
  job_t    q_out;
  logic    q_empty;
  logic    clearing;
  result_t result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bucket_mult  <= 32'd1;
      cfg.slot_mult    <= 32'd1;
      cfg.bucket_count <= 12'd2048;
      cfg.slot_modulus <= 8'd255;
      cfg.needed_count <= 5'd0;
    end else if (wr_en) begin
      case (wr_index)
        REG_BUCKET_MULT:  cfg.bucket_mult  <= wr_data;
        REG_SLOT_MULT:    cfg.slot_mult    <= wr_data;
        REG_BUCKET_COUNT: cfg.bucket_count <= wr_data[11:0];
        REG_SLOT_MODULUS: cfg.slot_modulus <= wr_data[7:0];
        REG_NEEDED_COUNT: cfg.needed_count <= wr_data[4:0];
        default: begin
        end
      endcase
    end
  end

  khfl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_in)
  );

  khfl_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_out),
    .empty    (q_empty)
  );

  khfl_back #(
    .BUCKETS        (BUCKETS),
    .NEEDED_ENTRIES (NEEDED_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_job    (q_out),
    .q_pop    (q_pop),
    .clearing (clearing),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_result (result)
  );

  // output word packing
  assign m_tdata = {7'b0, result.needed_index, result.matched, result.slot,
                    result.filter_hit, result.bucket};

endmodule

// ===== rtl/khfl_fifo.sv =====
// ----------------------------------------------------------------------------
// khfl_fifo
// Short job queue between the front and back stages.
// ----------------------------------------------------------------------------
module khfl_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  khfl_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output khfl_pkg::job_t pop_job,
  output logic          empty
);
  import khfl_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  job_t             store [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   count;

  assign full    = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = store[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wptr] <= push_job;
    end
  end

endmodule

// ===== rtl/khfl_front.sv =====
// ----------------------------------------------------------------------------
// khfl_front
// Accepts words, runs both string hashes per key byte, queues jobs.
// ----------------------------------------------------------------------------
module khfl_front (
  input  logic           clk,
  input  logic           rst,
  input  khfl_pkg::cfg_t cfg,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [23:0]    s_tdata,
  input  logic [1:0]     s_tuser,
  input  logic           s_tlast,
  input  logic           clearing,
  input  logic           q_full,
  output logic           q_push,
  output khfl_pkg::job_t q_job
);
  import khfl_pkg::*;

  logic [31:0] bucket_hash;
  logic [31:0] slot_hash;
  logic [31:0] bucket_hash_next;
  logic [31:0] slot_hash_next;
  logic        accept;
  logic [7:0]  data_byte;

  assign s_tready  = !clearing && !q_full;
  assign accept    = s_tvalid && s_tready;
  assign data_byte = s_tdata[7:0];

  // one multiply per hash per byte, low 32 bits kept
  assign bucket_hash_next = (bucket_hash ^ {24'b0, data_byte}) * cfg.bucket_mult;
  assign slot_hash_next   = (slot_hash ^ {24'b0, data_byte}) * cfg.slot_mult;

  // classify the word and build a job
  always_comb begin
    q_push = 1'b0;
    q_job  = '{kind: JOB_LOOKUP, h0: bucket_hash_next, h1: slot_hash_next};
    case (s_tuser)
      OP_KEY: begin
        q_push = accept && s_tlast;
      end
      OP_DELTA: begin
        q_push = accept;
        q_job  = '{kind: JOB_DELTA, h0: {24'b0, data_byte}, h1: 32'b0};
      end
      OP_TABLE: begin
        q_push = accept;
        q_job  = '{kind: JOB_TABLE, h0: {28'b0, s_tdata[11:8]}, h1: {24'b0, s_tdata[19:12]}};
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  // running hashes, back to 1 after a key end
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_hash <= 32'd1;
      slot_hash   <= 32'd1;
    end else if (accept && s_tuser == OP_KEY) begin
      if (s_tlast) begin
        bucket_hash <= 32'd1;
        slot_hash   <= 32'd1;
      end else begin
        bucket_hash <= bucket_hash_next;
        slot_hash   <= slot_hash_next;
      end
    end
  end

endmodule

// ===== rtl/khfl_back.sv =====
// ----------------------------------------------------------------------------
// khfl_back
// Runs queued jobs: bitmap clear and load, table writes, and lookups with
// bit-serial remainders, bitmap read and needed-slot compare.
// ----------------------------------------------------------------------------
module khfl_back #(
  parameter int BUCKETS        = khfl_pkg::DEFAULT_BUCKETS,
  parameter int NEEDED_ENTRIES = khfl_pkg::DEFAULT_NEEDED_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  khfl_pkg::cfg_t    cfg,
  input  logic              q_empty,
  input  khfl_pkg::job_t    q_job,
  output logic              q_pop,
  output logic              clearing,
  output logic              m_valid,
  input  logic              m_ready,
  output khfl_pkg::result_t m_result
);
  import khfl_pkg::*;

  localparam int IDX_W = $clog2(BUCKETS);
  localparam int POS_W = $clog2(BUCKETS + 256);
  localparam int NE_W  = (NEEDED_ENTRIES > 1) ? $clog2(NEEDED_ENTRIES) : 1;
  localparam logic [16:0]      BUCKETS_17 = 17'(BUCKETS);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(BUCKETS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_CMP
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] clr_addr;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_sum;
  logic             delta_ok;

  // remainder unit
  logic [31:0] bq;
  logic [31:0] sq;
  logic [11:0] brem;
  logic [7:0]  srem;
  logic [11:0] nb_q;
  logic [7:0]  mo_q;
  logic [4:0]  cnt;
  logic [12:0] btrial;
  logic [8:0]  strial;
  logic [11:0] nb_eff;
  logic [7:0]  mo_eff;

  // bitmap memory
  logic             bitmap [BUCKETS];
  logic             mem_we;
  logic [IDX_W-1:0] mem_addr;
  logic             mem_wdata;
  logic [16:0]      brem_ext;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_bit;

  // needed slot table
  logic [7:0]  needed [NEEDED_ENTRIES];
  logic [5:0]  tbl_idx;
  logic [7:0]  slot_val;
  logic [NEEDED_ENTRIES-1:0] hit_vec;
  logic [3:0]  match_idx;

  assign clearing = (state == ST_CLEAR);
  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign pos_sum  = pos + POS_W'(q_job.h0[7:0]);
  assign delta_ok = (pos_sum < POS_W'(BUCKETS));
  assign tbl_idx  = {2'b0, q_job.h0[3:0]};
  assign brem_ext = {5'b0, brem};
  assign rd_addr  = brem_ext[IDX_W-1:0];

  // effective moduli
  always_comb begin
    if (cfg.bucket_count == '0) begin
      nb_eff = 12'd1;
    end else if ({5'b0, cfg.bucket_count} > BUCKETS_17) begin
      nb_eff = 12'(BUCKETS);
    end else begin
      nb_eff = cfg.bucket_count;
    end
    mo_eff = (cfg.slot_modulus == '0) ? 8'd1 : cfg.slot_modulus;
  end

  // one restoring step per cycle on both remainders
  assign btrial = {brem, bq[31]};
  assign strial = {srem, sq[31]};

  // bitmap write port: clearing sweep or filter delta
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = clr_addr;
    mem_wdata = 1'b0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (q_pop && q_job.kind == JOB_DELTA && delta_ok) begin
      mem_we    = 1'b1;
      mem_addr  = pos_sum[IDX_W-1:0];
      mem_wdata = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      rd_bit <= bitmap[rd_addr];
    end
  end

  // table writes
  always_ff @(posedge clk) begin
    if (q_pop && q_job.kind == JOB_TABLE && tbl_idx < 6'(NEEDED_ENTRIES)) begin
      needed[tbl_idx[NE_W-1:0]] <= q_job.h1[7:0];
    end
  end

  // slot compare, lowest matching entry wins
  assign slot_val = rd_bit ? srem : 8'd0;
  always_comb begin
    for (int i = 0; i < NEEDED_ENTRIES; i++) begin
      hit_vec[i] = (6'(i) < {1'b0, cfg.needed_count}) && (needed[i] == slot_val);
    end
    match_idx = 4'd0;
    for (int i = NEEDED_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        match_idx = 4'(i);
      end
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      pos      <= '0;
      m_valid  <= 1'b0;
    end else begin
      // result taken; a new one in ST_CMP sets it again below
      if (m_valid && m_ready && state != ST_CMP) begin
        m_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            case (q_job.kind)
              JOB_LOOKUP: begin
                bq    <= q_job.h0;
                sq    <= q_job.h1;
                brem  <= '0;
                srem  <= '0;
                nb_q  <= nb_eff;
                mo_q  <= mo_eff;
                cnt   <= '0;
                state <= ST_DIV;
              end
              JOB_DELTA: begin
                if (delta_ok) begin
                  pos <= pos_sum;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIV: begin
          bq   <= {bq[30:0], 1'b0};
          sq   <= {sq[30:0], 1'b0};
          brem <= (btrial >= {1'b0, nb_q}) ? 12'(btrial - {1'b0, nb_q}) : btrial[11:0];
          srem <= (strial >= {1'b0, mo_q}) ? 8'(strial - {1'b0, mo_q}) : strial[7:0];
          cnt  <= cnt + 1'b1;
          if (cnt == 5'd31) begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (!m_valid || m_ready) begin
            m_valid               <= 1'b1;
            m_result.bucket       <= brem[10:0];
            m_result.filter_hit   <= rd_bit;
            m_result.slot         <= slot_val;
            m_result.matched      <= rd_bit && (|hit_vec);
            m_result.needed_index <= (rd_bit && (|hit_vec)) ? match_idx : 4'd0;
            state                 <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "keyword_hash_filter_lookup_assert.svh"

  `KHFL_ASSERT_NOW(a_brem_range, state == ST_DIV || state == ST_RD, brem < nb_q, "bucket remainder out of range")
  `KHFL_ASSERT_NOW(a_srem_range, state == ST_DIV || state == ST_RD, srem < mo_q, "slot remainder out of range")
  `KHFL_ASSERT_NOW(a_pos_range, 1'b1, pos < POS_W'(BUCKETS), "filter position past bitmap")
  `KHFL_ASSERT_NOW(a_match_hit, m_valid && m_result.matched, m_result.filter_hit, "match without filter hit")
  `KHFL_ASSERT_NEXT(a_no_pop_clear, state == ST_CLEAR, !q_pop, "queue popped during clear")

endmodule
